>>> design/lla_pkg.sv
// shared types and constants for the life-like automaton grid block
package lla_pkg;

   typedef enum logic [1:0] {
      FN_READ    = 2'd0,
      FN_WRITE   = 2'd1,
      FN_ADVANCE = 2'd2,
      FN_CLEAR   = 2'd3
   } lla_func_type;

   typedef enum logic [2:0] {
      REG_GRID_WIDTH  = 3'd0,
      REG_GRID_HEIGHT = 3'd1,
      REG_SURVIVE_MIN = 3'd2,
      REG_SURVIVE_MAX = 3'd3,
      REG_BIRTH_COUNT = 3'd4,
      REG_ALIVE_LEVEL = 3'd5,
      REG_DECAY_STEP  = 3'd6
   } lla_reg_type;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      lla_func_type func;
      logic [5:0]   col;
      logic [5:0]   row;
      logic [7:0]   cell_in;
   } lla_req_type;

   typedef struct packed {
      logic [7:0] cell_out;
      logic       op_done;
   } lla_rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      lla_func_type func;
      logic         in_area;
      logic [5:0]   col;
      logic [5:0]   row;
      logic [7:0]   cell_in;
   } lla_cmd_type;

   // status from back to front
   typedef struct packed {
      logic pop;
      logic init;
   } lla_stat_type;

   typedef struct packed {
      logic [3:0] survive_min;
      logic [3:0] survive_max;
      logic [3:0] birth_count;
      logic [7:0] alive_level;
      logic [7:0] decay_step;
   } lla_rule_type;

endpackage

>>> design/life_like_automaton_grid_step.sv
// top level of the life-like automaton grid: config registers, front end and back end
//
// A toroidal grid of 8-bit cells, MAX_COLS x MAX_ROWS stored, of which the
// configured width x height is active. An item is taken when start is high
// and busy is low; func selects read, write, advance one generation or clear.
// Every item gives exactly one result, shown for one cycle with rsp_valid;
// the receiver cannot hold it off.
// Items land in a two-entry queue, so busy drops back while the back end works.
// A write answers straight from the idle state; a read passes the read state first.
// A clear writes every stored cell, one per cycle.
// A generation copies the whole grid to a snapshot memory one cell a cycle,
// then for each active cell makes nine reads of the single snapshot read port
// plus a write back.
// After reset the block clears the grid with busy high and gives no result for
// that pass. Configuration registers are written through csr_we/csr_idx/csr_wdata;
// the user writes them only while no item is in progress; the block does not check.
module life_like_automaton_grid_step #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lla_pkg::lla_req_type  req_data,
   output logic                  rsp_valid,
   output lla_pkg::lla_rsp_type  rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_idx,
   input  logic [7:0]            csr_wdata
);
   import lla_pkg::*;

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);

   logic [6:0]      grid_width_ff;
   logic [6:0]      grid_height_ff;
   lla_rule_type    rule_ff;
   logic [CW:0]     act_cols;
   logic [RW:0]     act_rows;
   lla_stat_type    stat;
   logic            cmd_valid;
   lla_cmd_type     cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff       <= 7'd64;
         grid_height_ff      <= 7'd64;
         rule_ff.survive_min <= 4'd2;
         rule_ff.survive_max <= 4'd3;
         rule_ff.birth_count <= 4'd3;
         rule_ff.alive_level <= 8'd255;
         rule_ff.decay_step  <= 8'd1;
      end else if (csr_we) begin
         case (csr_idx)
            REG_GRID_WIDTH:  grid_width_ff       <= csr_wdata[6:0];
            REG_GRID_HEIGHT: grid_height_ff      <= csr_wdata[6:0];
            REG_SURVIVE_MIN: rule_ff.survive_min <= csr_wdata[3:0];
            REG_SURVIVE_MAX: rule_ff.survive_max <= csr_wdata[3:0];
            REG_BIRTH_COUNT: rule_ff.birth_count <= csr_wdata[3:0];
            REG_ALIVE_LEVEL: rule_ff.alive_level <= csr_wdata;
            REG_DECAY_STEP:  rule_ff.decay_step  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // active size, clamped to 3..MAX
   always_comb begin
      if (grid_width_ff < 7'd3) begin
         act_cols = (CW+1)'(3);
      end else if (32'(grid_width_ff) > MAX_COLS) begin
         act_cols = (CW+1)'(MAX_COLS);
      end else begin
         act_cols = (CW+1)'(grid_width_ff);
      end
      if (grid_height_ff < 7'd3) begin
         act_rows = (RW+1)'(3);
      end else if (32'(grid_height_ff) > MAX_ROWS) begin
         act_rows = (RW+1)'(MAX_ROWS);
      end else begin
         act_rows = (RW+1)'(grid_height_ff);
      end
   end

   lla_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .act_cols  (act_cols),
      .act_rows  (act_rows),
      .stat      (stat),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   lla_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .act_cols  (act_cols),
      .act_rows  (act_rows),
      .rule      (rule_ff),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

>>> design/lla_ram.sv
// generic single-write, single-read ram with registered read data
module lla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> design/lla_front.sv
// front end: accepts items, checks coordinates and queues them for the back end
module lla_front #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lla_pkg::lla_req_type          req_data,
   input  logic [$clog2(MAX_COLS):0]     act_cols,
   input  logic [$clog2(MAX_ROWS):0]     act_rows,
   input  lla_pkg::lla_stat_type         stat,
   output logic                          cmd_valid,
   output lla_pkg::lla_cmd_type          cmd
);
   import lla_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   lla_cmd_type     q_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wptr_ff;
   logic [PW-1:0]   rptr_ff;
   logic [PW:0]     count_ff;
   logic            push;
   lla_cmd_type     entry;

   assign busy = (count_ff == (PW+1)'(QUEUE_DEPTH)) || stat.init;
   assign push = start && !busy;

   always_comb begin
      entry.func    = req_data.func;
      entry.in_area = (32'(req_data.col) < 32'(act_cols)) &&
                      (32'(req_data.row) < 32'(act_rows));
      entry.col     = req_data.col;
      entry.row     = req_data.row;
      entry.cell_in = req_data.cell_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= entry;
      end
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (32'(wptr_ff) == QUEUE_DEPTH - 1) ? '0 : wptr_ff + 1'b1;
         end
         if (stat.pop) begin
            rptr_ff <= (32'(rptr_ff) == QUEUE_DEPTH - 1) ? '0 : rptr_ff + 1'b1;
         end
         if (push && !stat.pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && stat.pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rptr_ff];
endmodule

>>> design/lla_back.sv
// back end: executes reads, writes, clears and generation sweeps on the grid memories
module lla_back #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  lla_pkg::lla_cmd_type          cmd,
   input  logic [$clog2(MAX_COLS):0]     act_cols,
   input  logic [$clog2(MAX_ROWS):0]     act_rows,
   input  lla_pkg::lla_rule_type         rule,
   output lla_pkg::lla_stat_type         stat,
   output logic                          rsp_valid,
   output lla_pkg::lla_rsp_type          rsp_data
);
   import lla_pkg::*;

   localparam int NCELLS = MAX_COLS * MAX_ROWS;
   localparam int AW = $clog2(NCELLS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_COPY, ST_NBR, ST_WB
   } state_type;

   state_type        state_ff;
   logic [AW:0]      cnt_ff;
   logic             init_ff;
   logic             cp_v_ff;
   logic [AW-1:0]    cp_addr_ff;
   logic [CW-1:0]    col_ff;
   logic [RW-1:0]    row_ff;
   logic [1:0]       kc_ff;
   logic [1:0]       kr_ff;
   logic             pend_v_ff;
   logic             pend_own_ff;
   logic [3:0]       nbr_cnt_ff;
   logic [7:0]       own_ff;
   logic             rd_in_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_cell_ff;

   logic             pop;
   logic [AW-1:0]    cmd_addr;
   logic [AW-1:0]    cell_addr;
   logic [CW-1:0]    lf, rt, ncol;
   logic [RW-1:0]    up, dn, nrow;
   logic             last_col, last_row;
   logic             live;
   logic [7:0]       next_cell;
   logic             cur_we;
   logic [AW-1:0]    cur_waddr, cur_raddr;
   logic [7:0]       cur_wdata, cur_rdata;
   logic [AW-1:0]    prev_raddr;
   logic [7:0]       prev_rdata;

   function automatic logic [AW-1:0] cell_index(input logic [CW-1:0] c,
                                                input logic [RW-1:0] r);
      cell_index = AW'(32'(r) * MAX_COLS + 32'(c));
   endfunction

   assign pop      = (state_ff == ST_IDLE) && cmd_valid;
   assign cmd_addr = cell_index(CW'(cmd.col), RW'(cmd.row));
   assign cell_addr = cell_index(col_ff, row_ff);

   // torus neighbours of the cell being computed
   assign last_col = ((CW+1)'(col_ff) + 1'b1) == act_cols;
   assign last_row = ((RW+1)'(row_ff) + 1'b1) == act_rows;
   assign lf = (col_ff == '0) ? CW'(act_cols - 1'b1) : col_ff - 1'b1;
   assign rt = last_col ? '0 : col_ff + 1'b1;
   assign up = (row_ff == '0) ? RW'(act_rows - 1'b1) : row_ff - 1'b1;
   assign dn = last_row ? '0 : row_ff + 1'b1;

   always_comb begin
      case (kc_ff)
         2'd0:    ncol = lf;
         2'd1:    ncol = col_ff;
         default: ncol = rt;
      endcase
      case (kr_ff)
         2'd0:    nrow = up;
         2'd1:    nrow = row_ff;
         default: nrow = dn;
      endcase
   end
   assign prev_raddr = cell_index(ncol, nrow);

   always_comb begin
      live = (own_ff == rule.alive_level);
      if ((!live && nbr_cnt_ff == rule.birth_count) ||
          (live && nbr_cnt_ff >= rule.survive_min && nbr_cnt_ff <= rule.survive_max)) begin
         next_cell = rule.alive_level;
      end else if (own_ff >= rule.decay_step) begin
         next_cell = own_ff - rule.decay_step;
      end else begin
         next_cell = '0;
      end
   end

   always_comb begin
      cur_we    = 1'b0;
      cur_waddr = cmd_addr;
      cur_wdata = cmd.cell_in;
      cur_raddr = (state_ff == ST_IDLE) ? cmd_addr : cnt_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            cur_we = pop && (cmd.func == FN_WRITE) && cmd.in_area;
         end
         ST_WB: begin
            cur_we    = 1'b1;
            cur_waddr = cell_addr;
            cur_wdata = next_cell;
         end
         ST_CLEAR: begin
            cur_we    = 1'b1;
            cur_waddr = cnt_ff[AW-1:0];
            cur_wdata = '0;
         end
         default: begin
            cur_we = 1'b0;
         end
      endcase
   end

   lla_ram #(.WIDTH(8), .DEPTH(NCELLS)) u_cur (
      .clock (clock),
      .we    (cur_we),
      .waddr (cur_waddr),
      .wdata (cur_wdata),
      .raddr (cur_raddr),
      .rdata (cur_rdata)
   );

   // snapshot of the grid taken at the start of a generation
   lla_ram #(.WIDTH(8), .DEPTH(NCELLS)) u_prev (
      .clock (clock),
      .we    (cp_v_ff),
      .waddr (cp_addr_ff),
      .wdata (cur_rdata),
      .raddr (prev_raddr),
      .rdata (prev_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         init_ff      <= 1'b1;
         cp_v_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  case (cmd.func)
                     FN_READ: begin
                        rd_in_ff <= cmd.in_area;
                        state_ff <= ST_READ;
                     end
                     FN_WRITE: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_cell_ff  <= '0;
                     end
                     FN_ADVANCE: begin
                        cnt_ff   <= '0;
                        cp_v_ff  <= 1'b0;
                        state_ff <= ST_COPY;
                     end
                     default: begin
                        cnt_ff   <= '0;
                        state_ff <= ST_CLEAR;
                     end
                  endcase
               end
            end
            ST_READ: begin
               rsp_valid_ff <= 1'b1;
               rsp_cell_ff  <= rd_in_ff ? cur_rdata : '0;
               state_ff     <= ST_IDLE;
            end
            ST_CLEAR: begin
               if (cnt_ff[AW-1:0] == AW'(NCELLS - 1)) begin
                  if (!init_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_cell_ff  <= '0;
                  end
                  init_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_COPY: begin
               if (cnt_ff != (AW+1)'(NCELLS)) begin
                  cp_v_ff    <= 1'b1;
                  cp_addr_ff <= cnt_ff[AW-1:0];
                  cnt_ff     <= cnt_ff + 1'b1;
               end else begin
                  cp_v_ff    <= 1'b0;
                  col_ff     <= '0;
                  row_ff     <= '0;
                  kc_ff      <= '0;
                  kr_ff      <= '0;
                  nbr_cnt_ff <= '0;
                  pend_v_ff  <= 1'b0;
                  state_ff   <= ST_NBR;
               end
            end
            ST_NBR: begin
               // one snapshot read per cycle, the registered data arrives in the following cycle
               if (pend_v_ff) begin
                  if (pend_own_ff) begin
                     own_ff <= prev_rdata;
                  end else if (prev_rdata == rule.alive_level) begin
                     nbr_cnt_ff <= nbr_cnt_ff + 1'b1;
                  end
               end
               if (kr_ff != 2'd3) begin
                  pend_v_ff   <= 1'b1;
                  pend_own_ff <= (kc_ff == 2'd1) && (kr_ff == 2'd1);
                  if (kc_ff == 2'd2) begin
                     kc_ff <= '0;
                     kr_ff <= kr_ff + 1'b1;
                  end else begin
                     kc_ff <= kc_ff + 1'b1;
                  end
               end else begin
                  pend_v_ff <= 1'b0;
                  state_ff  <= ST_WB;
               end
            end
            ST_WB: begin
               kc_ff      <= '0;
               kr_ff      <= '0;
               nbr_cnt_ff <= '0;
               state_ff   <= ST_NBR;
               if (last_col) begin
                  col_ff <= '0;
                  if (last_row) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_cell_ff  <= '0;
                     state_ff     <= ST_IDLE;
                  end else begin
                     row_ff <= row_ff + 1'b1;
                  end
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign stat.pop  = pop;
   assign stat.init = init_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.cell_out = rsp_cell_ff;
   assign rsp_data.op_done  = 1'b1;
endmodule
